// File: sv/hs_pkg.sv
`timescale 1ns / 1ps

package hs_pkg;

  // store size and derived widths
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CHILD_W   = ADDR_W + 2;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_FILL,
    OP_START,
    OP_BLD_RD,
    OP_BLD_LD,
    OP_SIFT_B,
    OP_EX_RD,
    OP_EX_LD,
    OP_SIFT_E,
    OP_OUT_RD,
    OP_OUT_LD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_fire;   // item flagged last taken this cycle
    logic n_small;     // fewer than two stored values
    logic k_one;       // loop index is one
    logic sift_done;   // sift step found no larger child
    logic out_free;    // result register can take a new value
    logic out_final;   // loop index points at the last stored value
  } sts_t;

endpackage

// File: sv/hs_item_if.sv
`timescale 1ns / 1ps

interface hs_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [hs_pkg::DATA_W-1:0]    value;
  logic                                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
  modport mon    (input valid, input value, input is_last, input ready);
endinterface

// File: sv/hs_result_if.sv
`timescale 1ns / 1ps

interface hs_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [hs_pkg::DATA_W-1:0]    sorted_value;
  logic                                last_out;
  logic                                overflowed;

  modport source (output valid, output sorted_value, output last_out, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflowed,
                  output ready);
  modport mon    (input valid, input sorted_value, input last_out, input overflowed,
                  input ready);
endinterface

// File: sv/hs_ram.sv
`timescale 1ns / 1ps

module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: sv/hs_dp.sv
`timescale 1ns / 1ps

module hs_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  hs_pkg::cmd_t                     cmd,
  output hs_pkg::sts_t                     sts,
  input  logic                             in_valid,
  input  logic signed [hs_pkg::DATA_W-1:0] in_value,
  input  logic                             in_is_last,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [hs_pkg::DATA_W-1:0] out_value,
  output logic                             out_last,
  output logic                             out_ovf
);

  logic [hs_pkg::CNT_W-1:0]          count;
  logic                              ovf;
  logic [hs_pkg::ADDR_W-1:0]         k;
  logic [hs_pkg::ADDR_W-1:0]         root;
  logic [hs_pkg::CNT_W-1:0]          len;
  logic signed [hs_pkg::DATA_W-1:0]  cur;

  logic                              we;
  logic [hs_pkg::ADDR_W-1:0]         waddr;
  logic [hs_pkg::DATA_W-1:0]         wdata;
  logic [hs_pkg::ADDR_W-1:0]         raddr_a;
  logic [hs_pkg::ADDR_W-1:0]         raddr_b;
  logic [hs_pkg::DATA_W-1:0]         rdata_a;
  logic [hs_pkg::DATA_W-1:0]         rdata_b;

  logic                              fire;
  logic                              full;
  logic [hs_pkg::CHILD_W-1:0]        lidx;
  logic [hs_pkg::CHILD_W-1:0]        ridx;
  logic                              take_l;
  logic                              take_r;
  logic                              move;
  logic signed [hs_pkg::DATA_W-1:0]  top_val;
  logic signed [hs_pkg::DATA_W-1:0]  sel_val;
  logic [hs_pkg::ADDR_W-1:0]         sel_idx;
  logic [hs_pkg::ADDR_W-1:0]         nroot;
  logic [hs_pkg::CHILD_W-1:0]        c1;
  logic [hs_pkg::CHILD_W-1:0]        c2;
  logic                              out_free;
  logic                              out_final;

  hs_ram #(
    .WIDTH (hs_pkg::DATA_W),
    .DEPTH (hs_pkg::MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign fire      = in_valid && (cmd.op == hs_pkg::OP_FILL);
  assign full      = (count == hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS));
  assign out_free  = !out_valid || out_ready;
  assign out_final = ((hs_pkg::CNT_W'(k) + 1'b1) == count);

  // one sift level: children of the current root arrive from the store
  always_comb begin
    lidx    = {1'b0, root, 1'b1};
    ridx    = {1'b0, root, 1'b0} + hs_pkg::CHILD_W'(2);
    take_l  = (lidx < hs_pkg::CHILD_W'(len)) && ($signed(rdata_a) > cur);
    top_val = take_l ? $signed(rdata_a) : cur;
    take_r  = (ridx < hs_pkg::CHILD_W'(len)) && ($signed(rdata_b) > top_val);
    move    = take_l || take_r;
    sel_val = take_r ? $signed(rdata_b) : $signed(rdata_a);
    sel_idx = take_r ? ridx[hs_pkg::ADDR_W-1:0] : lidx[hs_pkg::ADDR_W-1:0];
  end

  // root whose children are fetched next
  always_comb begin
    unique case (cmd.op)
      hs_pkg::OP_BLD_LD: nroot = k - 1'b1;
      hs_pkg::OP_EX_LD:  nroot = '0;
      default:           nroot = sel_idx;
    endcase
    c1 = {1'b0, nroot, 1'b1};
    c2 = {1'b0, nroot, 1'b0} + hs_pkg::CHILD_W'(2);
  end

  // store addressing
  always_comb begin
    we      = 1'b0;
    waddr   = root;
    wdata   = move ? sel_val : cur;
    raddr_a = k;
    raddr_b = k;
    unique case (cmd.op)
      hs_pkg::OP_FILL: begin
        we    = fire && !full;
        waddr = count[hs_pkg::ADDR_W-1:0];
        wdata = in_value;
      end
      hs_pkg::OP_BLD_RD: begin
        raddr_a = k - 1'b1;
      end
      hs_pkg::OP_BLD_LD: begin
        raddr_a = c1[hs_pkg::ADDR_W-1:0];
        raddr_b = c2[hs_pkg::ADDR_W-1:0];
      end
      hs_pkg::OP_EX_RD: begin
        raddr_a = '0;
      end
      hs_pkg::OP_EX_LD: begin
        we      = 1'b1;
        waddr   = k;
        wdata   = rdata_a;
        raddr_a = c1[hs_pkg::ADDR_W-1:0];
        raddr_b = c2[hs_pkg::ADDR_W-1:0];
      end
      hs_pkg::OP_SIFT_B, hs_pkg::OP_SIFT_E: begin
        we      = 1'b1;
        raddr_a = c1[hs_pkg::ADDR_W-1:0];
        raddr_b = c2[hs_pkg::ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result valid: set on a load, cleared when taken
      if ((cmd.op == hs_pkg::OP_OUT_LD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        hs_pkg::OP_FILL: begin
          if (fire) begin
            if (!full) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        hs_pkg::OP_START: begin
          k   <= hs_pkg::ADDR_W'(count >> 1);
          len <= count;
        end
        hs_pkg::OP_BLD_LD: begin
          cur  <= $signed(rdata_a);
          root <= k - 1'b1;
        end
        hs_pkg::OP_EX_LD: begin
          cur  <= $signed(rdata_b);
          root <= '0;
          len  <= hs_pkg::CNT_W'(k);
        end
        hs_pkg::OP_SIFT_B: begin
          if (move) begin
            root <= sel_idx;
          end else if (k == hs_pkg::ADDR_W'(1)) begin
            k <= hs_pkg::ADDR_W'(count - 1'b1);
          end else begin
            k <= k - 1'b1;
          end
        end
        hs_pkg::OP_SIFT_E: begin
          if (move) begin
            root <= sel_idx;
          end else if (k == hs_pkg::ADDR_W'(1)) begin
            k <= '0;
          end else begin
            k <= k - 1'b1;
          end
        end
        hs_pkg::OP_OUT_LD: begin
          if (out_free) begin
            out_value <= $signed(rdata_a);
            out_last  <= out_final;
            out_ovf   <= ovf;
            if (out_final) begin
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // status to the sequencer
  always_comb begin
    sts.last_fire = fire && in_is_last;
    sts.n_small   = (count < hs_pkg::CNT_W'(2));
    sts.k_one     = (k == hs_pkg::ADDR_W'(1));
    sts.sift_done = !move;
    sts.out_free  = out_free;
    sts.out_final = out_final;
  end

endmodule

// File: sv/hs_ctrl.sv
`timescale 1ns / 1ps

module hs_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  hs_pkg::sts_t sts,
  output hs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_FILL,
    S_START,
    S_BLD_RD,
    S_BLD_LD,
    S_BSIFT,
    S_EX_RD,
    S_EX_LD,
    S_ESIFT,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  state_t state;

  // operation per state
  always_comb begin
    unique case (state)
      S_FILL:   cmd.op = hs_pkg::OP_FILL;
      S_START:  cmd.op = hs_pkg::OP_START;
      S_BLD_RD: cmd.op = hs_pkg::OP_BLD_RD;
      S_BLD_LD: cmd.op = hs_pkg::OP_BLD_LD;
      S_BSIFT:  cmd.op = hs_pkg::OP_SIFT_B;
      S_EX_RD:  cmd.op = hs_pkg::OP_EX_RD;
      S_EX_LD:  cmd.op = hs_pkg::OP_EX_LD;
      S_ESIFT:  cmd.op = hs_pkg::OP_SIFT_E;
      S_OUT_RD: cmd.op = hs_pkg::OP_OUT_RD;
      S_OUT_LD: cmd.op = hs_pkg::OP_OUT_LD;
      default:  cmd.op = hs_pkg::OP_FILL;
    endcase
  end

  // sequencer: collect, build heap, extract, emit (build and extract skipped for under two values)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      unique case (state)
        S_FILL: begin
          if (sts.last_fire) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= sts.n_small ? S_OUT_RD : S_BLD_RD;
        end
        S_BLD_RD: state <= S_BLD_LD;
        S_BLD_LD: state <= S_BSIFT;
        S_BSIFT: begin
          if (sts.sift_done) begin
            state <= sts.k_one ? S_EX_RD : S_BLD_RD;
          end
        end
        S_EX_RD: state <= S_EX_LD;
        S_EX_LD: state <= S_ESIFT;
        S_ESIFT: begin
          if (sts.sift_done) begin
            state <= sts.k_one ? S_OUT_RD : S_EX_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          if (sts.out_free) begin
            state <= sts.out_final ? S_FILL : S_OUT_RD;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

// File: sv/heap_sorter.sv
`timescale 1ns / 1ps

// channel   dir   fields                                 item
// items     in    value[31:0] s, is_last                 one list element
// results   out   sorted_value[31:0] s, last_out,        one sorted element
//                 overflowed
//
// collecting accepts one item per cycle; the sort starts after the item marked last
// sort of n values: build the heap, then extract; each sift goes down levels <= log2(n),
// reading both children of a level at once from the two-read-port store
// emit: each result is a store read, then a result register load
// reset clears the sequencer, the count, the overflow flag and the result valid;
// the store itself is not cleared
// items is ready only while collecting; a stalled result holds the sequencer

module heap_sorter (
  input logic         clk,
  input logic         rst,
  hs_item_if.sink     items,
  hs_result_if.source results
);

  hs_pkg::cmd_t cmd;
  hs_pkg::sts_t sts;

  assign items.ready = (cmd.op == hs_pkg::OP_FILL);

  hs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  hs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_valid   (items.valid),
    .in_value   (items.value),
    .in_is_last (items.is_last),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_value  (results.sorted_value),
    .out_last   (results.last_out),
    .out_ovf    (results.overflowed)
  );

endmodule

// File: sv/hs_check.sv
`timescale 1ns / 1ps

module hs_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [hs_pkg::DATA_W-1:0] out_value,
  input logic                             out_last,
  input logic                             out_ovf
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // the last item of a list stops intake while sorting
  a_stop_intake: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_last |=> !in_ready)
    else $error("intake open after last item");

  // results of one list come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_last |=>
      !out_valid || (out_value >= $past(out_value)))
    else $error("results not ascending");

  // one overflow flag for the whole list
  a_ovf_const: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_last |=>
      !out_valid || (out_ovf == $past(out_ovf)))
    else $error("overflow flag changed within a list");

endmodule

bind heap_sorter hs_check u_hs_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_last   (items.is_last),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.sorted_value),
  .out_last  (results.last_out),
  .out_ovf   (results.overflowed)
);
